### rtl/overwrite_oldest_sample_fifo_assert.svh
// assertion macros for the overwrite-oldest sample fifo
// used by the datapath; the bodies are empty when SYNTHESIS is defined
`ifndef OVERWRITE_OLDEST_SAMPLE_FIFO_ASSERT_SVH
`define OVERWRITE_OLDEST_SAMPLE_FIFO_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define OOSF_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define OOSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define OOSF_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define OOSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/oosf_pkg.sv
// shared types and constants of the overwrite-oldest sample fifo
// no dependencies; used by the interfaces, controller, datapath and top level
`default_nettype none

package oosf_pkg;

	// fixed field widths of the transaction payloads
	localparam int SAMPLE_FIELD_W = 64;
	localparam int LEVEL_W        = 7;
	localparam int DROP_W         = 32;
	localparam int STATUS_W       = 2;

	// operation codes
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STS_PUSHED    = 2'd0;
	localparam logic [STATUS_W-1:0] STS_OVERWROTE = 2'd1;
	localparam logic [STATUS_W-1:0] STS_POPPED    = 2'd2;
	localparam logic [STATUS_W-1:0] STS_EMPTY     = 2'd3;

	// controller states, one-hot
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic capture; // latch the incoming operation, start the store read
		logic commit;  // apply the operation and load the result register
	} cmd_t;

endpackage

`default_nettype wire

### rtl/oosf_if.sv
// valid/ready channel interfaces for operations in and results out
// depends on oosf_pkg for the payload widths
`default_nettype none

interface oosf_in_if;
	logic                                valid;
	logic                                ready;
	logic                                func;
	logic [oosf_pkg::SAMPLE_FIELD_W-1:0] sample_data;

	modport source (output valid, output func, output sample_data, input ready);
	modport sink (input valid, input func, input sample_data, output ready);
endinterface

interface oosf_out_if;
	logic                                valid;
	logic                                ready;
	logic [oosf_pkg::STATUS_W-1:0]       status;
	logic [oosf_pkg::SAMPLE_FIELD_W-1:0] popped_data;
	logic [oosf_pkg::LEVEL_W-1:0]        fill_level;
	logic [oosf_pkg::DROP_W-1:0]         dropped_total;
	logic [oosf_pkg::LEVEL_W-1:0]        peak_fill;

	modport source (output valid, output status, output popped_data, output fill_level,
		output dropped_total, output peak_fill, input ready);
	modport sink (input valid, input status, input popped_data, input fill_level,
		input dropped_total, input peak_fill, output ready);
endinterface

`default_nettype wire

### rtl/oosf_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module oosf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/oosf_ctrl.sv
// controller: channel handshakes, operation sequencing, result valid flag
// depends on oosf_pkg
`default_nettype none

module oosf_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	output oosf_pkg::cmd_t      cmd
);

	oosf_pkg::state_t state_q;
	oosf_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;

	// a new operation is taken whenever no operation is in flight
	assign in_ready    = (state_q == oosf_pkg::ST_IDLE);
	assign out_free    = !out_valid_q || out_ready;
	assign cmd.capture = in_valid && in_ready;
	assign cmd.commit  = (state_q == oosf_pkg::ST_EXEC) && out_free;
	assign out_valid   = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			oosf_pkg::ST_IDLE: begin
				if (cmd.capture) begin
					state_d = oosf_pkg::ST_EXEC;
				end
			end
			oosf_pkg::ST_EXEC: begin
				if (cmd.commit) begin
					state_d = oosf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = oosf_pkg::ST_IDLE;
			end
		endcase
	end

	// state and result valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= oosf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/oosf_dp.sv
// datapath: pointers, fill count, drop counter, watermark, sample store, result register
// depends on oosf_pkg, oosf_ram and the assertion macro header
`default_nettype none
`include "overwrite_oldest_sample_fifo_assert.svh"

module oosf_dp #(
	parameter int DEPTH        = 64,
	parameter int SAMPLE_WIDTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire oosf_pkg::cmd_t                        cmd,
	input  wire logic                                  func,
	input  wire logic [oosf_pkg::SAMPLE_FIELD_W-1:0]   sample_data,
	output logic      [oosf_pkg::STATUS_W-1:0]         status,
	output logic      [oosf_pkg::SAMPLE_FIELD_W-1:0]   popped_data,
	output logic      [oosf_pkg::LEVEL_W-1:0]          fill_level,
	output logic      [oosf_pkg::DROP_W-1:0]           dropped_total,
	output logic      [oosf_pkg::LEVEL_W-1:0]          peak_fill
);

	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WIDE_W = (CNT_W > oosf_pkg::LEVEL_W) ? CNT_W : oosf_pkg::LEVEL_W;

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	// operation latched at capture
	logic                    op_pop_s1;
	logic [SAMPLE_WIDTH-1:0] op_data_s1;

	// buffer state
	logic [PTR_W-1:0]            wr_ptr_q;
	logic [PTR_W-1:0]            rd_ptr_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [CNT_W-1:0]            peak_q;
	logic [oosf_pkg::DROP_W-1:0] drop_cnt_q;

	// result register
	logic [oosf_pkg::STATUS_W-1:0]       status_q;
	logic [oosf_pkg::SAMPLE_FIELD_W-1:0] sample_q;
	logic [oosf_pkg::LEVEL_W-1:0]        fill_q;
	logic [oosf_pkg::DROP_W-1:0]         drop_out_q;
	logic [oosf_pkg::LEVEL_W-1:0]        peak_out_q;

	// next-state values
	logic                                full;
	logic                                empty;
	logic [PTR_W-1:0]                    wr_ptr_inc;
	logic [PTR_W-1:0]                    rd_ptr_inc;
	logic [PTR_W-1:0]                    wr_ptr_d;
	logic [PTR_W-1:0]                    rd_ptr_d;
	logic [CNT_W-1:0]                    cnt_d;
	logic [CNT_W-1:0]                    peak_d;
	logic [oosf_pkg::DROP_W-1:0]         drop_d;
	logic [oosf_pkg::STATUS_W-1:0]       status_d;
	logic [oosf_pkg::SAMPLE_FIELD_W-1:0] sample_d;
	logic [WIDE_W-1:0]                   cnt_wide;
	logic [WIDE_W-1:0]                   peak_wide;
	logic                                mem_we;
	logic [SAMPLE_WIDTH-1:0]             mem_rdata;

	// sample store: read at capture, written at commit of a push
	assign mem_we = cmd.commit && !op_pop_s1;

	oosf_ram #(
		.WIDTH (SAMPLE_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_ptr_q),
		.wdata (op_data_s1),
		.re    (cmd.capture),
		.raddr (rd_ptr_q),
		.rdata (mem_rdata)
	);

	// latch the operation
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_pop_s1  <= (func == oosf_pkg::FUNC_POP);
			op_data_s1 <= sample_data[SAMPLE_WIDTH-1:0];
		end
	end

	// pointer wrap
	assign full       = (cnt_q == CNT_FULL);
	assign empty      = (cnt_q == '0);
	assign wr_ptr_inc = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
	assign rd_ptr_inc = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);

	// operation outcome
	always_comb begin
		wr_ptr_d = wr_ptr_q;
		rd_ptr_d = rd_ptr_q;
		cnt_d    = cnt_q;
		drop_d   = drop_cnt_q;
		peak_d   = peak_q;
		sample_d = '0;
		if (!op_pop_s1) begin
			wr_ptr_d = wr_ptr_inc;
			if (full) begin
				// oldest entry gives way to the new sample
				status_d = oosf_pkg::STS_OVERWROTE;
				rd_ptr_d = rd_ptr_inc;
				drop_d   = drop_cnt_q + oosf_pkg::DROP_W'(1);
			end else begin
				status_d = oosf_pkg::STS_PUSHED;
				cnt_d    = cnt_q + CNT_W'(1);
			end
			if (cnt_d > peak_q) begin
				peak_d = cnt_d;
			end
		end else if (!empty) begin
			status_d = oosf_pkg::STS_POPPED;
			sample_d = oosf_pkg::SAMPLE_FIELD_W'(mem_rdata);
			rd_ptr_d = rd_ptr_inc;
			cnt_d    = cnt_q - CNT_W'(1);
		end else begin
			status_d = oosf_pkg::STS_EMPTY;
		end
	end

	// levels reported modulo 128
	assign cnt_wide  = WIDE_W'(cnt_d);
	assign peak_wide = WIDE_W'(peak_d);

	// buffer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			cnt_q      <= '0;
			peak_q     <= '0;
			drop_cnt_q <= '0;
		end else if (cmd.commit) begin
			wr_ptr_q   <= wr_ptr_d;
			rd_ptr_q   <= rd_ptr_d;
			cnt_q      <= cnt_d;
			peak_q     <= peak_d;
			drop_cnt_q <= drop_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q   <= status_d;
			sample_q   <= sample_d;
			fill_q     <= cnt_wide[oosf_pkg::LEVEL_W-1:0];
			drop_out_q <= drop_d;
			peak_out_q <= peak_wide[oosf_pkg::LEVEL_W-1:0];
		end
	end

	assign status        = status_q;
	assign popped_data   = sample_q;
	assign fill_level    = fill_q;
	assign dropped_total = drop_out_q;
	assign peak_fill     = peak_out_q;

	// checks
	`OOSF_ASSERT_ALWAYS(a_cnt_in_range, clk, arst_n, cnt_q <= CNT_FULL, "fill count above depth")
	`OOSF_ASSERT_ALWAYS(a_ptr_meet, clk, arst_n, (!empty && !full) || (wr_ptr_q == rd_ptr_q), "pointers disagree with fill count")
	`OOSF_ASSERT_ALWAYS(a_peak_ge_cnt, clk, arst_n, peak_q >= cnt_q, "watermark below fill count")
	`OOSF_ASSERT_NEXT(a_drop_hold, clk, arst_n, !cmd.commit, $stable(drop_cnt_q), "drop counter moved without an operation")
	`OOSF_ASSERT_NEXT(a_drop_step, clk, arst_n, cmd.commit, (drop_cnt_q == $past(drop_cnt_q)) || (drop_cnt_q == $past(drop_cnt_q) + oosf_pkg::DROP_W'(1)), "drop counter jumped")

endmodule

`default_nettype wire

### rtl/overwrite_oldest_sample_fifo.sv
// top level of the overwrite-oldest sample fifo
// depends on oosf_pkg, oosf_if, oosf_ctrl, oosf_dp (and through it oosf_ram)
//
// Usage:
//   in_ch carries one operation per transaction: func 0 pushes sample_data
//   (low SAMPLE_WIDTH bits kept), func 1 pops the oldest stored sample.
//   out_ch returns exactly one result per operation: status, popped sample
//   (zero unless popped), fill level, dropped count and peak fill level.
//   A push into a full buffer overwrites the oldest sample and counts it.
//   out_ch.valid is registered and rises when the operation commits, which
//   follows the accepting edge as soon as out_ch is free to take a result.
//   The sample store has a registered read port, so an operation is read at
//   capture and committed after it; no new operation is taken until it commits.
//   in_ch.ready stays high while a finished result waits on out_ch, so the next
//   operation is read ahead; it commits once out_ch frees up.
//   When the receiver stalls, the result holds and at most one further operation
//   waits inside, then in_ch.ready drops.
//   Reset empties the buffer and clears the drop count and watermark at once;
//   store contents are not cleared, since an entry is only read after a write.
`default_nettype none

module overwrite_oldest_sample_fifo #(
	parameter int DEPTH        = 64,
	parameter int SAMPLE_WIDTH = 64
) (
	input wire logic    clk,
	input wire logic    arst_n,
	oosf_in_if.sink     in_ch,
	oosf_out_if.source  out_ch
);

	oosf_pkg::cmd_t cmd;

	// sequencing and handshakes
	oosf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	// buffer state and result payload
	oosf_dp #(
		.DEPTH        (DEPTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.func          (in_ch.func),
		.sample_data   (in_ch.sample_data),
		.status        (out_ch.status),
		.popped_data   (out_ch.popped_data),
		.fill_level    (out_ch.fill_level),
		.dropped_total (out_ch.dropped_total),
		.peak_fill     (out_ch.peak_fill)
	);

endmodule

`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the overwrite-oldest sample fifo
// depends on oosf_pkg, oosf_if and the overwrite_oldest_sample_fifo rtl
`timescale 1ns / 100ps

module tb_top;

	localparam int DEPTH    = 64;
	localparam int SAMPLE_W = 64;
	localparam logic [oosf_pkg::SAMPLE_FIELD_W-1:0] SAMPLE_MASK =
		{oosf_pkg::SAMPLE_FIELD_W{1'b1}} >> (oosf_pkg::SAMPLE_FIELD_W - SAMPLE_W);
	localparam int TOTAL_OPS = 1000;
	localparam int MAX_GAP   = 18;

	typedef struct {
		logic                                op;
		logic [oosf_pkg::SAMPLE_FIELD_W-1:0] data;
		int unsigned                         gap;
	} fifo_op_t;

	typedef struct {
		logic [oosf_pkg::STATUS_W-1:0]       status;
		logic [oosf_pkg::SAMPLE_FIELD_W-1:0] sample;
		logic [oosf_pkg::LEVEL_W-1:0]        level;
		logic [oosf_pkg::DROP_W-1:0]         drops;
		logic [oosf_pkg::LEVEL_W-1:0]        peak;
	} fifo_result_t;

	logic clk;
	logic arst_n;

	oosf_in_if  in_ch ();
	oosf_out_if out_ch ();

	overwrite_oldest_sample_fifo #(
		.DEPTH       (DEPTH),
		.SAMPLE_WIDTH(SAMPLE_W)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	// shadow copy of the buffer state
	logic [oosf_pkg::SAMPLE_FIELD_W-1:0] shadow_store [DEPTH];
	int                                  wr_idx;
	int                                  rd_idx;
	int                                  held;
	logic [oosf_pkg::DROP_W-1:0]         drops;
	int                                  peak;

	fifo_op_t     pending_ops [$];
	fifo_result_t due_results [$];
	fifo_op_t     next_op;
	fifo_result_t got_result;
	fifo_result_t want_result;
	int unsigned  send_wait;
	int unsigned  rx_wait;
	int unsigned  rx_draw;
	int unsigned  hold_left;
	bit           hold_done;
	bit           tx_calm;
	bit           rx_calm;
	int           results_seen;
	int           error_count;

	function automatic int step_idx(input int p);
		return (p + 1 >= DEPTH) ? 0 : p + 1;
	endfunction

	// apply one operation to the shadow state and return its result
	function automatic fifo_result_t predict_fifo_op(input logic op,
		input logic [oosf_pkg::SAMPLE_FIELD_W-1:0] data);
		fifo_result_t r;
		r.sample = '0;
		if (op == oosf_pkg::FUNC_PUSH) begin
			r.status = oosf_pkg::STS_PUSHED;
			if (held >= DEPTH) begin
				r.status = oosf_pkg::STS_OVERWROTE;
				drops = drops + 1'b1;
				rd_idx = step_idx(rd_idx);
				held = held - 1;
			end
			shadow_store[wr_idx] = data & SAMPLE_MASK;
			wr_idx = step_idx(wr_idx);
			held = held + 1;
			if (held > peak)
				peak = held;
		end else if (held > 0) begin
			r.status = oosf_pkg::STS_POPPED;
			r.sample = shadow_store[rd_idx] & SAMPLE_MASK;
			rd_idx = step_idx(rd_idx);
			held = held - 1;
		end else begin
			r.status = oosf_pkg::STS_EMPTY;
		end
		r.level = oosf_pkg::LEVEL_W'(held);
		r.drops = drops;
		r.peak  = oosf_pkg::LEVEL_W'(peak);
		return r;
	endfunction

	// sample record with a bias toward the extremes
	function automatic logic [oosf_pkg::SAMPLE_FIELD_W-1:0] rand_sample();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic add_op(input logic op, input logic [oosf_pkg::SAMPLE_FIELD_W-1:0] data);
		fifo_op_t t;
		if ($urandom_range(0, 39) == 0)
			tx_calm = !tx_calm;
		t.op   = op;
		t.data = data;
		t.gap  = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
		pending_ops.push_back(t);
	endtask

	task automatic check_field(input string name,
		input logic [oosf_pkg::SAMPLE_FIELD_W-1:0] want,
		input logic [oosf_pkg::SAMPLE_FIELD_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $realtime, name, want, got);
			error_count++;
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// reset, stimulus and end of run
	initial begin
		int kind;
		int len;
		int n_ops;
		in_ch.valid       = 1'b0;
		in_ch.func        = oosf_pkg::FUNC_PUSH;
		in_ch.sample_data = '0;
		out_ch.ready      = 1'b0;
		arst_n            = 1'b0;
		wr_idx            = 0;
		rd_idx            = 0;
		held              = 0;
		drops             = '0;
		peak              = 0;
		error_count       = 0;
		tx_calm           = 1'b0;
		rx_calm           = 1'b0;

		// directed: pop on empty, extreme records, drain past empty
		add_op(oosf_pkg::FUNC_POP, '1);
		add_op(oosf_pkg::FUNC_PUSH, '0);
		add_op(oosf_pkg::FUNC_PUSH, '1);
		add_op(oosf_pkg::FUNC_PUSH, {32{2'b10}});
		add_op(oosf_pkg::FUNC_PUSH, {32{2'b01}});
		add_op(oosf_pkg::FUNC_PUSH, 64'h8000_0000_0000_0000);
		add_op(oosf_pkg::FUNC_PUSH, 64'h1);
		repeat (7)
			add_op(oosf_pkg::FUNC_POP, rand_sample());
		add_op(oosf_pkg::FUNC_PUSH, 64'h0123_4567_89ab_cdef);
		add_op(oosf_pkg::FUNC_POP, '0);
		add_op(oosf_pkg::FUNC_POP, '0);

		// fill past full for overwrite and pointer wrap, then drain
		repeat (70)
			add_op(oosf_pkg::FUNC_PUSH, rand_sample());
		repeat (70)
			add_op(oosf_pkg::FUNC_POP, rand_sample());

		// random runs: push heavy, pop heavy and mixed
		while (pending_ops.size() < TOTAL_OPS) begin
			kind = $urandom_range(0, 9);
			len  = $urandom_range(1, (kind >= 7) ? 40 : 80);
			repeat (len) begin
				if (kind <= 3)
					add_op(($urandom_range(0, 9) == 0) ? oosf_pkg::FUNC_POP
						: oosf_pkg::FUNC_PUSH, rand_sample());
				else if (kind <= 6)
					add_op(($urandom_range(0, 9) == 0) ? oosf_pkg::FUNC_PUSH
						: oosf_pkg::FUNC_POP, rand_sample());
				else
					add_op($urandom_range(0, 1) ? oosf_pkg::FUNC_POP
						: oosf_pkg::FUNC_PUSH, rand_sample());
			end
		end
		n_ops = pending_ops.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// wait until every transaction has come back
		while (results_seen < n_ops)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0 && due_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// run limit
	initial begin
		#1_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// driver: offer queued operations with their idle gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid       <= 1'b0;
			in_ch.func        <= oosf_pkg::FUNC_PUSH;
			in_ch.sample_data <= '0;
			send_wait         <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				due_results.push_back(predict_fifo_op(in_ch.func, in_ch.sample_data));
			if (!in_ch.valid || in_ch.ready) begin
				if (send_wait != 0) begin
					send_wait   <= send_wait - 1;
					in_ch.valid <= 1'b0;
				end else if (pending_ops.size() != 0) begin
					next_op = pending_ops.pop_front();
					in_ch.valid       <= 1'b1;
					in_ch.func        <= next_op.op;
					in_ch.sample_data <= next_op.data;
					send_wait         <= next_op.gap;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls plus one long hold to back up the input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rx_wait      <= 0;
			hold_left    <= 0;
			hold_done    <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			out_ch.ready <= (hold_left == 1);
		end else if (!hold_done && results_seen >= 300) begin
			hold_done    <= 1'b1;
			hold_left    <= 400;
			out_ch.ready <= 1'b0;
		end else if (out_ch.valid && out_ch.ready) begin
			if ($urandom_range(0, 39) == 0)
				rx_calm = !rx_calm;
			rx_draw = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
			rx_wait      <= rx_draw;
			out_ch.ready <= (rx_draw == 0);
		end else if (rx_wait != 0) begin
			rx_wait      <= rx_wait - 1;
			out_ch.ready <= (rx_wait == 1);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// monitor: compare each result transaction with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_seen <= 0;
		end else if (out_ch.valid && out_ch.ready) begin
			results_seen <= results_seen + 1;
			got_result.status = out_ch.status;
			got_result.sample = out_ch.popped_data;
			got_result.level  = out_ch.fill_level;
			got_result.drops  = out_ch.dropped_total;
			got_result.peak   = out_ch.peak_fill;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, expected none actual status %h sample %h",
					$realtime, got_result.status, got_result.sample);
				error_count++;
			end else begin
				want_result = due_results.pop_front();
				check_field("status", want_result.status, got_result.status);
				check_field("popped_data", want_result.sample, got_result.sample);
				check_field("fill_level", want_result.level, got_result.level);
				check_field("dropped_total", want_result.drops, got_result.drops);
				check_field("peak_fill", want_result.peak, got_result.peak);
			end
		end
	end

endmodule
